FILE: rtl/core/mbsp_pkg.sv
// Shared types, sizes and helpers of the masked box smoothing block.
// Used by the controller, the datapath and the top level; no dependencies.

package mbsp_pkg;

   // patch geometry
   localparam int PatchWidth  = 16;
   localparam int PatchHeight = 16;
   localparam int RingRows    = 3;
   localparam int RingDepth   = RingRows * PatchWidth;

   // sample and arithmetic widths
   localparam int SampleW        = 16;
   localparam int IntensityFracW = 16;
   localparam int WordW          = 2 * SampleW;
   localparam int KernelMax      = 9;
   localparam int CountW         = $clog2(KernelMax + 1);
   localparam int SumW           = SampleW + CountW;
   localparam int RemW           = CountW + 1;
   localparam int DivCntW        = $clog2(SumW);

   // counter and address widths
   localparam int AddrW = $clog2(RingDepth);
   localparam int ColW  = $clog2(PatchWidth);
   localparam int RowW  = $clog2(PatchHeight);

   typedef logic [1:0]       slot_type;
   typedef logic [1:0]       kidx_type;
   typedef logic [ColW-1:0]  col_type;
   typedef logic [RowW-1:0]  row_type;
   typedef logic [AddrW-1:0] addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_KERNEL,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_DIAG,
      PH_EDGE,
      PH_LAST,
      PH_DONE
   } phase_type;

   // kernel position inside the 3x3 window
   localparam kidx_type KFirst = 2'd0;
   localparam kidx_type KMid   = 2'd1;
   localparam kidx_type KLast  = 2'd2;

   typedef struct packed {
      logic     wr;
      logic     rd;
      addr_type addr;
      logic     acc_clear;
      logic     acc;
      logic     center;
      logic     div_init;
      logic     div_step;
      logic     mul;
      logic     load;
      logic     last;
   } dp_cmd_type;

   function automatic slot_type slot_prev(input slot_type s);
      slot_type r;
      r = (s == slot_type'(0)) ? slot_type'(RingRows - 1) : s - slot_type'(1);
      return r;
   endfunction

   function automatic slot_type slot_next(input slot_type s);
      slot_type r;
      r = (s == slot_type'(RingRows - 1)) ? slot_type'(0) : s + slot_type'(1);
      return r;
   endfunction

   function automatic addr_type ring_addr(input slot_type s, input col_type c);
      addr_type r;
      r = addr_type'(s) * addr_type'(PatchWidth) + addr_type'(c);
      return r;
   endfunction

endpackage

FILE: rtl/core/masked_box_smooth_patch.sv
// Top level of the masked box smoothing block.
// Depends on mbsp_pkg, mbsp_ctrl and mbsp_dp (which holds mbsp_ram).

// A 16x16 patch of height samples enters in raster order, one word per
// sample, and every position leaves as the edge-normalized mean of itself and
// its in-bounds neighbors (cross of four, or all eight with large_kernel set),
// rounded to nearest and blended back toward the original height by the
// sample's Q0.16 brush intensity (zero intensity means full smoothing).
// Results come out in raster order: a sample releases the result one row up
// and one column left once that position's lower-right neighbor is present,
// the last column of a row follows the row below it, and the final sample of
// the patch releases the two pending results of the row above and then the
// whole bottom row, so that word yields 18 results.
// Sequence: after accepting a word the controller spends a dispatch step
// on each result it schedules and one on each scheduling step that finds
// nothing. Each scheduled result then passes through a nine-step walk
// over the 3x3 window (reading each included position from the ring
// memory), a drain step, a divider setup step, a 20-step bit-serial divide
// by the count of included samples, a multiply step and an output step.
// A stalled rsp_ side holds only the output step of the next result.
// The finished result sits in an output register, so a stalled rsp_ side
// does not hold up the next accepted word until another result is ready.
// The ring memory needs no clearing: only positions of the current patch that
// are already written are ever read. Write large_kernel only while idle.

module masked_box_smooth_patch (
   input  logic        clock,
   input  logic        reset,

   // configuration: large_kernel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,

   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] height_sample, [31:16] brush_intensity

   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] smoothed_height
   output logic        rsp_tlast    // last_of_patch
);
   import mbsp_pkg::*;

   dp_cmd_type cmd;

   // register writes complete in the same cycle
   assign csr_ready = 1'b1;

   mbsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   mbsp_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

FILE: rtl/core/mbsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mbsp_ram #(
   parameter int Width = 32,
   parameter int Depth = 48
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/mbsp_ctrl.sv
// Controller of the masked box smoothing block: position counters, result
// scheduling, kernel walk and divider sequencing. Depends on mbsp_pkg.

module mbsp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               csr_valid,
   input  logic               csr_data,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output mbsp_pkg::dp_cmd_type cmd
);
   import mbsp_pkg::*;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   row_type    row_ff, row_in;
   col_type    col_ff, col_in;
   slot_type   slot_ff, slot_in;
   row_type    sr_ff, sr_in;
   col_type    sc_ff, sc_in;
   slot_type   ss_ff, ss_in;
   row_type    tr_ff, tr_in;
   col_type    tc_ff, tc_in;
   slot_type   ts_ff, ts_in;
   col_type    jc_ff, jc_in;
   kidx_type   kr_ff, kr_in;
   kidx_type   kc_ff, kc_in;
   logic [DivCntW-1:0] dcnt_ff, dcnt_in;
   logic       large_ff, large_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       incl_ff, incl_in;
   logic       center_ff, center_in;

   logic       accept;
   logic       take;
   row_type    job_r;
   col_type    job_c;
   slot_type   job_s;
   phase_type  job_phase;
   logic       incl;
   logic       kend;
   logic       out_free;
   slot_type   rd_slot;
   col_type    rd_col;

   localparam row_type LastRow = row_type'(PatchHeight - 1);
   localparam col_type LastCol = col_type'(PatchWidth - 1);

   assign accept   = req_tvalid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign kend     = (kr_ff == KLast) && (kc_ff == KLast);

   // pick the next result owed by the sample just written
   always_comb begin
      take      = 1'b0;
      job_r     = sr_ff;
      job_c     = sc_ff;
      job_s     = ss_ff;
      job_phase = phase_ff;
      unique case (phase_ff)
         PH_DIAG: begin
            take      = (sr_ff != row_type'(0)) && (sc_ff != col_type'(0));
            job_r     = sr_ff - row_type'(1);
            job_c     = sc_ff - col_type'(1);
            job_s     = slot_prev(ss_ff);
            job_phase = PH_EDGE;
         end
         PH_EDGE: begin
            take      = (sr_ff != row_type'(0)) && (sc_ff == LastCol);
            job_r     = sr_ff - row_type'(1);
            job_c     = LastCol;
            job_s     = slot_prev(ss_ff);
            job_phase = PH_LAST;
         end
         PH_LAST: begin
            take      = (sr_ff == LastRow) && (sc_ff == LastCol);
            job_r     = sr_ff;
            job_c     = jc_ff;
            job_s     = ss_ff;
            job_phase = (take && (jc_ff != LastCol)) ? PH_LAST : PH_DONE;
         end
         PH_DONE: begin
            take      = 1'b0;
         end
         default: begin
            take      = 1'b0;
         end
      endcase
   end

   // neighbor selection for the current kernel position
   always_comb begin
      logic row_ok;
      logic col_ok;
      logic diag;
      row_ok = !((kr_ff == KFirst) && (tr_ff == row_type'(0))) &&
               !((kr_ff == KLast) && (tr_ff == LastRow));
      col_ok = !((kc_ff == KFirst) && (tc_ff == col_type'(0))) &&
               !((kc_ff == KLast) && (tc_ff == LastCol));
      diag   = (kr_ff != KMid) && (kc_ff != KMid);
      incl   = row_ok && col_ok && (!diag || large_ff);
      unique case (kr_ff)
         KFirst:  rd_slot = slot_prev(ts_ff);
         KLast:   rd_slot = slot_next(ts_ff);
         default: rd_slot = ts_ff;
      endcase
      rd_col = tc_ff + col_type'(kc_ff) - col_type'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (phase_ff == PH_DONE) begin
               state_in = ST_IDLE;
            end else if (take) begin
               state_in = ST_KERNEL;
            end
         end
         ST_KERNEL:   if (kend) state_in = ST_DRAIN;
         ST_DRAIN:    state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV:      if (dcnt_ff == DivCntW'(SumW - 1)) state_in = ST_MUL;
         ST_MUL:      state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_DISPATCH;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      cmd           = '0;
      req_tready    = (state_ff == ST_IDLE);
      cmd.wr        = accept;
      cmd.addr      = (state_ff == ST_IDLE) ? ring_addr(slot_ff, col_ff)
                                            : ring_addr(rd_slot, rd_col);
      cmd.rd        = (state_ff == ST_KERNEL) && incl;
      cmd.acc_clear = (state_ff == ST_DISPATCH) && take;
      cmd.acc       = incl_ff;
      cmd.center    = center_ff;
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.mul       = (state_ff == ST_MUL);
      cmd.load      = (state_ff == ST_OUT) && out_free;
      cmd.last      = (tr_ff == LastRow) && (tc_ff == LastCol);
   end

   // counters and held positions
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      slot_in      = slot_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      ss_in        = ss_ff;
      tr_in        = tr_ff;
      tc_in        = tc_ff;
      ts_in        = ts_ff;
      jc_in        = jc_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      phase_in     = phase_ff;
      dcnt_in      = dcnt_ff;
      large_in     = csr_valid ? csr_data : large_ff;
      incl_in      = (state_ff == ST_KERNEL) && incl;
      center_in    = (state_ff == ST_KERNEL) && (kr_ff == KMid) && (kc_ff == KMid);
      rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_tready);

      if (accept) begin
         // hold the position just written, advance to the next one
         sr_in    = row_ff;
         sc_in    = col_ff;
         ss_in    = slot_ff;
         jc_in    = col_type'(0);
         phase_in = PH_DIAG;
         if (col_ff == LastCol) begin
            col_in = col_type'(0);
            if (row_ff == LastRow) begin
               row_in  = row_type'(0);
               slot_in = slot_type'(0);
            end else begin
               row_in  = row_ff + row_type'(1);
               slot_in = slot_next(slot_ff);
            end
         end else begin
            col_in = col_ff + col_type'(1);
         end
      end

      if (state_ff == ST_DISPATCH) begin
         phase_in = job_phase;
         if (take) begin
            tr_in = job_r;
            tc_in = job_c;
            ts_in = job_s;
            kr_in = KFirst;
            kc_in = KFirst;
            if (phase_ff == PH_LAST) begin
               jc_in = jc_ff + col_type'(1);
            end
         end
      end

      if (state_ff == ST_KERNEL) begin
         if (kc_ff == KLast) begin
            kc_in = KFirst;
            kr_in = kr_ff + kidx_type'(1);
         end else begin
            kc_in = kc_ff + kidx_type'(1);
         end
      end

      if (state_ff == ST_DIV_INIT) begin
         dcnt_in = '0;
      end else if (state_ff == ST_DIV) begin
         dcnt_in = dcnt_ff + DivCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_DONE;
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         large_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         incl_ff      <= 1'b0;
         center_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         slot_ff      <= slot_in;
         large_ff     <= large_in;
         rsp_valid_ff <= rsp_valid_in;
         incl_ff      <= incl_in;
         center_ff    <= center_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff   <= sr_in;
      sc_ff   <= sc_in;
      ss_ff   <= ss_in;
      tr_ff   <= tr_in;
      tc_ff   <= tc_in;
      ts_ff   <= ts_in;
      jc_ff   <= jc_in;
      kr_ff   <= kr_in;
      kc_ff   <= kc_in;
      dcnt_ff <= dcnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/core/mbsp_dp.sv
// Datapath of the masked box smoothing block: three-row ring memory,
// neighbor accumulator, bit-serial divider, blend multiply and output word.
// Depends on mbsp_pkg and mbsp_ram.

module mbsp_dp (
   input  logic                         clock,
   input  mbsp_pkg::dp_cmd_type         cmd,
   input  logic [mbsp_pkg::WordW-1:0]   req_tdata,
   output logic [mbsp_pkg::SampleW-1:0] rsp_tdata,
   output logic                         rsp_tlast
);
   import mbsp_pkg::*;

   logic [WordW-1:0]   rd_word;
   logic [SampleW-1:0] rd_h;
   logic [SampleW-1:0] rd_i;

   logic [SumW-1:0]    sum_ff, sum_in;
   logic [CountW-1:0]  cnt_ff, cnt_in;
   logic [SampleW-1:0] h_ff, h_in;
   logic [SampleW-1:0] i_ff, i_in;
   logic [SumW-1:0]    num_ff, num_in;
   logic [RemW-1:0]    rem_ff, rem_in;
   logic signed [SampleW:0] scl_ff, scl_in;
   logic [SampleW-1:0] out_ff, out_in;
   logic               last_ff, last_in;

   logic [RemW-1:0]    trial;
   logic               ge;
   logic signed [SampleW:0]       delta;
   logic signed [2*SampleW+1:0]   prod;
   logic signed [SampleW+1:0]     res;

   mbsp_ram #(
      .Width(WordW),
      .Depth(RingDepth)
   ) u_ring (
      .clock (clock),
      .we    (cmd.wr),
      .waddr (cmd.addr),
      .wdata (req_tdata),
      .re    (cmd.rd),
      .raddr (cmd.addr),
      .rdata (rd_word)
   );

   assign rd_h = rd_word[SampleW-1:0];
   assign rd_i = rd_word[WordW-1:SampleW];

   // restoring divider step: one quotient bit per cycle
   assign trial = {rem_ff[RemW-2:0], num_ff[SumW-1]};
   assign ge    = trial >= RemW'(cnt_ff);

   assign delta = $signed({1'b0, h_ff}) - $signed({1'b0, num_ff[SampleW-1:0]});
   assign prod  = delta * $signed({1'b0, i_ff});
   assign res   = $signed({2'b00, h_ff}) - $signed({scl_ff[SampleW], scl_ff});

   always_comb begin
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      h_in    = h_ff;
      i_in    = i_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      scl_in  = scl_ff;
      out_in  = out_ff;
      last_in = last_ff;

      if (cmd.acc_clear) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (cmd.acc) begin
         sum_in = sum_ff + SumW'(rd_h);
         cnt_in = cnt_ff + CountW'(1);
      end

      if (cmd.center) begin
         h_in = rd_h;
         i_in = rd_i;
      end

      if (cmd.div_init) begin
         // bias by half the count for round-to-nearest
         num_in = sum_ff + SumW'(cnt_ff >> 1);
         rem_in = '0;
      end else if (cmd.div_step) begin
         num_in = {num_ff[SumW-2:0], ge};
         rem_in = ge ? (trial - RemW'(cnt_ff)) : trial;
      end

      if (cmd.mul) begin
         // floor of delta * intensity / 2^16; zero intensity keeps delta
         scl_in = (i_ff != '0) ? prod[IntensityFracW+SampleW:IntensityFracW] : delta;
      end

      if (cmd.load) begin
         priority if (res < 0) begin
            out_in = '0;
         end else if (res > $signed({2'b00, {SampleW{1'b1}}})) begin
            out_in = {SampleW{1'b1}};
         end else begin
            out_in = res[SampleW-1:0];
         end
         last_in = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      h_ff    <= h_in;
      i_ff    <= i_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      scl_ff  <= scl_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_tdata = out_ff;
   assign rsp_tlast = last_ff;

endmodule

FILE: rtl/core/mbsp_checker.sv
// Port-level checks of the masked box smoothing block, bound to the top level.
// Depends only on the ports of masked_box_smooth_patch.

module mbsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // no result word right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // ready to take a word right after reset
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

   // an accepted word is scheduled before the next is taken
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on back-to-back cycles");

endmodule

bind masked_box_smooth_patch mbsp_checker u_mbsp_checker (.*);

FILE: sim/masked_box_smooth_patch_test.sv
// Self-checking testbench of the masked box smoothing block.
// Depends on mbsp_pkg and masked_box_smooth_patch; it uses no other file directly.
`timescale 1ns / 100ps

module masked_box_smooth_patch_test;
   import mbsp_pkg::*;

   localparam int DirectedCount = 24;
   localparam int RandomTarget  = 356;
   localparam int IdleSettle    = 40;
   localparam int TailCycles    = 80;
   localparam int WatchdogLimit = 4000;

   // one expected result word
   typedef struct packed {
      logic [15:0] height;
      logic        last;
   } smooth_word_type;

   // Shadow of the block: a three-row ring of samples, the raster position and
   // the kernel mode. Every accepted sample is stored here and the results it
   // releases are computed at once and queued in emission order.
   class smooth_tracker_type;
      logic [15:0]     height_ring [RingDepth];
      logic [15:0]     weight_ring [RingDepth];
      int unsigned     col;
      int unsigned     row;
      bit              large_kernel;
      smooth_word_type pending_words[$];
      int              errors;
      int              results_seen;

      function new();
         for (int i = 0; i < RingDepth; i++) begin
            height_ring[i] = '0;
            weight_ring[i] = '0;
         end
         col = 0;
         row = 0;
         large_kernel = 0;
         errors = 0;
         results_seen = 0;
      endfunction

      function int unsigned slot_of(int unsigned r, int unsigned c);
         return (r % RingRows) * PatchWidth + c;
      endfunction

      // edge-normalized mean, blended toward the center by its intensity
      function logic [15:0] smoothed_at(int unsigned r, int unsigned c);
         int     sum;
         int     count;
         int     rr;
         int     cc;
         int     center;
         int     mean;
         int     delta;
         int     blended;
         longint product;
         sum = 0;
         count = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               rr = int'(r) + dr;
               cc = int'(c) + dc;
               if (dr != 0 && dc != 0 && !large_kernel) continue;
               if (rr < 0 || rr >= PatchHeight || cc < 0 || cc >= PatchWidth) continue;
               sum += int'(height_ring[slot_of(rr, cc)]);
               count++;
            end
         end
         center = int'(height_ring[slot_of(r, c)]);
         mean = (sum + count / 2) / count;
         delta = center - mean;
         if (weight_ring[slot_of(r, c)] != 16'd0) begin
            // floor of delta * intensity / 2^16, also for negative deltas
            product = longint'(delta) * longint'(weight_ring[slot_of(r, c)]);
            delta = int'(product >>> 16);
         end
         blended = center - delta;
         if (blended < 0) blended = 0;
         if (blended > 65535) blended = 65535;
         return blended[15:0];
      endfunction

      function void release_result(int unsigned r, int unsigned c);
         smooth_word_type w;
         w.height = smoothed_at(r, c);
         w.last = (r == PatchHeight - 1) && (c == PatchWidth - 1);
         pending_words.push_back(w);
      endfunction

      // note one accepted sample and queue what it releases
      function void take_sample(logic [15:0] height, logic [15:0] weight);
         height_ring[slot_of(row, col)] = height;
         weight_ring[slot_of(row, col)] = weight;
         if (row >= 1) begin
            if (col >= 1) release_result(row - 1, col - 1);
            if (col == PatchWidth - 1) release_result(row - 1, col);
         end
         if (row == PatchHeight - 1 && col == PatchWidth - 1) begin
            for (int j = 0; j < PatchWidth; j++) release_result(row, j);
         end
         col++;
         if (col >= PatchWidth) begin
            col = 0;
            row = (row + 1 >= PatchHeight) ? 0 : row + 1;
         end
      endfunction

      // compare one accepted result word with the oldest expectation
      function void check_result(logic [15:0] height, logic last);
         smooth_word_type w;
         results_seen++;
         if (pending_words.size() == 0) begin
            $error("unexpected result: smoothed_height %0d, last_of_patch %0b", height, last);
            errors++;
            return;
         end
         w = pending_words.pop_front();
         if (height !== w.height) begin
            $error("smoothed_height: expected %0d, actual %0d", w.height, height);
            errors++;
         end
         if (last !== w.last) begin
            $error("last_of_patch: expected %0b, actual %0b", w.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_words.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   smooth_tracker_type tracker = new();

   int          burst_left = 4;
   int          samples_sent = 0;
   int          kernel_writes = 0;
   int          idle_cycles = 0;
   int unsigned rx_cycle = 0;
   logic [15:0] prev_height = 16'h8000;

   masked_box_smooth_patch DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: check every accepted result word, then pick the next ready.
   // The pattern cycles through always ready, random stalls and stall blocks.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(rsp_tdata, rsp_tlast);
      end
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 250) % 3)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(2) != 0);
         end
         default: begin
            rsp_tready <= ((rx_cycle % 16) < 5);
         end
      endcase
   end

   // Watchdog: count cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offer one sample and hold it until accepted; end the burst with a gap.
   task automatic send_sample(input logic [15:0] height, input logic [15:0] weight);
      int gap;
      req_tdata <= {weight, height};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.take_sample(height, weight);
      samples_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         // mostly short bursts, now and then a long stretch with no gaps
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      end
   endtask

   // Drop valid, wait until every result has arrived, then let the block settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (IdleSettle) @(posedge clock);
   endtask

   task automatic write_kernel(input logic large_mode);
      csr_data <= large_mode;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.large_kernel = large_mode;
      kernel_writes++;
   endtask

   // Random sample: extremes and near-flat runs next to fully random heights,
   // zero intensity (full smoothing) often, tiny and full-scale weights too.
   task automatic random_sample(output logic [15:0] height, output logic [15:0] weight);
      case ($urandom_range(9))
         0: height = 16'h0000;
         1: height = 16'hFFFF;
         2, 3: height = prev_height + 16'($urandom_range(64)) - 16'd32;
         default: height = 16'($urandom);
      endcase
      case ($urandom_range(9))
         0, 1, 2: weight = 16'h0000;
         3: weight = 16'hFFFF;
         4: weight = 16'($urandom_range(1, 16));
         default: weight = 16'($urandom);
      endcase
      prev_height = height;
   endtask

   initial begin
      logic [15:0] height;
      logic [15:0] weight;
      logic        kernel_mode;
      int          random_sent;
      int          phase_len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: the top row and part of the next with extreme heights
      // side by side, and zero, unit, half and full-scale intensities
      write_kernel(1'b0);
      for (int i = 0; i < DirectedCount; i++) begin
         case (i % 4)
            0: height = 16'h0000;
            1: height = 16'hFFFF;
            2: height = 16'h8000;
            default: height = 16'h7FFF;
         endcase
         case (i % 5)
            0: weight = 16'h0000;
            1: weight = 16'hFFFF;
            2: weight = 16'h0001;
            3: weight = 16'h8000;
            default: weight = 16'hAAAA;
         endcase
         send_sample(height, weight);
      end

      // random phases; kernel switches mostly land mid-patch, so results of
      // one patch come under both neighborhoods
      kernel_mode = 1'b1;
      random_sent = 0;
      while (random_sent < RandomTarget) begin
         drain_results();
         write_kernel(kernel_mode);
         phase_len = $urandom_range(40, 90);
         if (phase_len > RandomTarget - random_sent) phase_len = RandomTarget - random_sent;
         for (int i = 0; i < phase_len; i++) begin
            random_sample(height, weight);
            send_sample(height, weight);
         end
         random_sent += phase_len;
         kernel_mode = ~kernel_mode;
      end

      drain_results();
      repeat (TailCycles) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         $error("%0d expected results never arrived", tracker.outstanding());
         tracker.errors += tracker.outstanding();
      end

      $display("Sent %0d samples (%0d full patches) and checked %0d results",
               samples_sent, samples_sent / (PatchWidth * PatchHeight), tracker.results_seen);
      $display("over %0d kernel writes alternating cross and full 3x3 mid-patch.",
               kernel_writes);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
